@@ rtl/tscm_pkg.sv @@
// Shared constants and action codes of the trigger slot color mixer.
`timescale 1ns / 1ps
package tscm_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam int ID_W    = 8;
  localparam int COLOR_W = 24;
  localparam int LEVEL_W = 8;
  localparam int ACT_W   = 2;
  localparam int ENTRY_W = ID_W + COLOR_W;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [LEVEL_W-1:0] BYTE_MAX = 8'hFF;

endpackage

@@ rtl/tscm_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module tscm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/trigger_slot_color_mixer_unit.sv @@
// Top level of the trigger slot color mixer: slot table scan and color sums.
//
//   channel | direction | tdata                               | tuser
//   in_     | slave     | [7:0] source_id, [31:8] mix_color   | [1:0] action
//   out_    | master    | [7:0] red, [15:8] green, [23:16] blue | -
//
// An add or remove raises a result only when it finds its slot, a clear always. The
// next transaction is taken after the pass over all slots, whose length is set by the single
// read port of the slot RAM, one slot per cycle.
// A clear empties the valid bits at once and then runs the same pass (all zero).
// Action code three is accepted and dropped.
// Reset clears the valid bits, so every slot reads as empty; no clearing pass.
// A stalled result holds the block in its final state until taken.
`timescale 1ns / 1ps
module trigger_slot_color_mixer_unit
  import tscm_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] source_id, [31:8] mix_color
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red_level, [15:8] green_level, [23:16] blue_level
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                  input logic [LEVEL_W-1:0] b);
    logic [LEVEL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEVEL_W] ? BYTE_MAX : s[LEVEL_W-1:0];
  endfunction

  state_t                  state_r;
  logic [ACT_W-1:0]        op_act_r;
  logic [ID_W-1:0]         op_id_r;
  logic [COLOR_W-1:0]      op_color_r;
  logic [CNT_W-1:0]        iss_cnt_r;
  logic                    chk_vld_r;
  logic [IDX_W-1:0]        chk_idx_r;
  logic                    found_r;
  logic [SLOT_COUNT-1:0]   valid_r;
  logic [LEVEL_W-1:0]      acc_red_r;
  logic [LEVEL_W-1:0]      acc_green_r;
  logic [LEVEL_W-1:0]      acc_blue_r;
  logic                    out_vld_r;
  logic [23:0]             out_data_r;

  logic                    in_fire;
  logic                    ram_re;
  logic                    ram_we;
  logic [ENTRY_W-1:0]      ram_wr_data;
  logic [ENTRY_W-1:0]      ram_rd_data;
  logic                    slot_live;
  logic [ID_W-1:0]         slot_id;
  logic [COLOR_W-1:0]      slot_color;
  logic                    hit;
  logic [ID_W-1:0]         new_id;
  logic [COLOR_W-1:0]      new_color;
  logic [ID_W-1:0]         eff_id;
  logic [COLOR_W-1:0]      eff_color;
  logic                    scan_last;
  logic                    result_due;
  logic                    out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_vld_r || out_tready;

  assign ram_re = (state_r == S_SCAN) && (iss_cnt_r < CNT_W'(SLOT_COUNT));

  assign slot_live  = valid_r[chk_idx_r];
  assign slot_id    = slot_live ? ram_rd_data[ID_W-1:0] : '0;
  assign slot_color = slot_live ? ram_rd_data[ENTRY_W-1:ID_W] : '0;

  always_comb begin
    hit       = 1'b0;
    new_id    = '0;
    new_color = '0;
    case (op_act_r)
      ACT_ADD: begin
        hit       = (slot_id == '0);
        new_id    = op_id_r;
        new_color = op_color_r;
      end
      ACT_REMOVE: begin
        hit = (slot_id == op_id_r);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    hit = hit && chk_vld_r && !found_r && (state_r == S_SCAN);
  end

  assign ram_we      = hit;
  assign ram_wr_data = {new_color, new_id};
  assign eff_id      = hit ? new_id : slot_id;
  assign eff_color   = hit ? new_color : slot_color;
  assign scan_last   = chk_vld_r && (chk_idx_r == IDX_W'(SLOT_COUNT - 1));
  assign result_due  = found_r || (op_act_r == ACT_CLEAR);

  tscm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(chk_idx_r),
    .wr_data(ram_wr_data),
    .re     (ram_re),
    .rd_addr(iss_cnt_r[IDX_W-1:0]),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
      iss_cnt_r <= '0;
    end else begin
      if (out_vld_r && out_tready && !(state_r == S_DONE && result_due)) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_act_r    <= in_tuser;
            op_id_r     <= in_tdata[ID_W-1:0];
            op_color_r  <= in_tdata[ID_W+COLOR_W-1:ID_W];
            iss_cnt_r   <= '0;
            chk_vld_r   <= 1'b0;
            found_r     <= 1'b0;
            acc_red_r   <= '0;
            acc_green_r <= '0;
            acc_blue_r  <= '0;
            if (in_tuser == ACT_CLEAR) begin
              valid_r <= '0;
            end
            if (in_tuser inside {ACT_ADD, ACT_REMOVE, ACT_CLEAR}) begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld_r <= ram_re;
          if (ram_re) begin
            chk_idx_r <= iss_cnt_r[IDX_W-1:0];
            iss_cnt_r <= iss_cnt_r + CNT_W'(1);
          end
          if (hit) begin
            found_r            <= 1'b1;
            valid_r[chk_idx_r] <= 1'b1;
          end
          if (chk_vld_r && eff_id != '0) begin
            acc_red_r   <= sat_add(acc_red_r, eff_color[7:0]);
            acc_green_r <= sat_add(acc_green_r, eff_color[15:8]);
            acc_blue_r  <= sat_add(acc_blue_r, eff_color[23:16]);
          end
          if (scan_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_due) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_vld_r  <= 1'b1;
            out_data_r <= {acc_blue_r, acc_green_r, acc_red_r};
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN) && chk_vld_r)
    else $error("slot write outside the scan");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> found_r && !ram_we)
    else $error("more than one slot written in a pass");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == S_DONE && $past(result_due))
    else $error("result raised outside the final state");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_act_r == ACT_CLEAR) |->
      acc_red_r == '0 && acc_green_r == '0 && acc_blue_r == '0)
    else $error("clear produced nonzero levels");

endmodule
